### rtl/core/etw_pkg.sv
// Package for the expiry timing wheel: command codes and sequencer states.
// No dependencies.
package etw_pkg;

  typedef enum logic [1:0] {
    CMD_INSERT  = 2'd0,
    CMD_TICK    = 2'd1,
    CMD_COLLECT = 2'd2,
    CMD_NONE    = 2'd3
  } cmd_t;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_MOD  = 6'b000010,
    ST_RD   = 6'b000100,
    ST_WR   = 6'b001000,
    ST_OUT  = 6'b010000,
    ST_LINK = 6'b100000
  } state_t;

endpackage

### rtl/core/etw_modsub.sv
// Shared compare-and-subtract unit: one step of reducing a value modulo the wheel length.
// Depends on nothing; one subtract step per cycle.
module etw_modsub #(
  parameter int VW = 9,
  parameter int LW = 5
) (
  input  logic [VW-1:0] val_i,
  input  logic [LW-1:0] len_i,
  output logic [VW-1:0] val_o,
  output logic          done_o
);
  logic [VW-1:0] len_ext;
  assign len_ext = VW'(len_i);
  assign done_o  = val_i < len_ext;
  assign val_o   = done_o ? val_i : val_i - len_ext;
endmodule

### rtl/core/expiry_timing_wheel.sv
// Expiry timing wheel top level: slot queues, expired queue, linked store.
// Depends on etw_pkg and etw_modsub.
//
// One command at a time: in_stall is high from acceptance until the
// sequencer is back in idle. Slot numbers are reduced modulo the active wheel
// length by repeated subtraction in one shared compare-and-subtract unit, one
// step per cycle. An insert passes through the MOD, RD, WR and OUT states, with
// a LINK state before OUT when the target slot already holds entries and the
// entry is stored. A tick takes the same states, with LINK when it splices onto
// a non-empty expired queue. A collect and an unknown command skip MOD; a
// collect adds LINK when it pops an entry. The next word can be accepted in the
// same cycle as the result appears. The result word waits in an output
// register; a stalled result holds the sequencer only when the next result is
// ready. The link store is read through registers at one address per cycle.
// No clearing pass after reset.
module expiry_timing_wheel
  import etw_pkg::*;
#(
  parameter int NUM_SLOTS  = 16,
  parameter int CAPACITY   = 1024,
  parameter int DESC_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [4:0]  cfg_wheel_length,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_command,
  input  logic [31:0] in_descriptor,
  input  logic [7:0]  in_expiration,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_expired_descriptor,
  output logic        out_found,
  output logic        out_dropped
);
  localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int AW = $clog2(CAPACITY);
  localparam int CW = AW + 1;
  localparam int VW = ((SW > 8) ? SW : 8) + 1;
  localparam int LW = $clog2(NUM_SLOTS + 1);

  logic [DESC_WIDTH-1:0] mem_val [CAPACITY];
  logic [AW-1:0]         mem_link[CAPACITY];
  logic [AW-1:0]         shead   [NUM_SLOTS];
  logic [AW-1:0]         stail   [NUM_SLOTS];

  state_t                state_r;
  logic [4:0]            wlen_r;
  logic [NUM_SLOTS-1:0]  sne_r;
  logic [AW-1:0]         ehead_r, etail_r, fhead_r;
  logic                  ene_r;
  logic [CW-1:0]         fcnt_r, fresh_r;
  logic [SW-1:0]         cur_r;
  cmd_t                  cmd_r;
  logic [DESC_WIDTH-1:0] desc_r;
  logic [VW-1:0]         acc_r;
  logic [AW-1:0]         node_r;
  logic [DESC_WIDTH-1:0] rval_r;
  logic [AW-1:0]         rlink_r;
  logic [AW-1:0]         sh_r, st_r;
  logic [AW-1:0]         lidx_r, ldat_r;
  logic [AW-1:0]         stail_q;
  logic [31:0]           res_desc_r;
  logic                  res_found_r, res_drop_r;
  logic                  ovalid_r;
  logic [31:0]           odesc_r;
  logic                  ofound_r, odrop_r;

  logic [LW-1:0]         alen;
  logic [VW-1:0]         sub_val;
  logic                  sub_done;
  logic [SW-1:0]         slot;
  logic                  alloc_ok;
  logic                  out_load;
  cmd_t                  in_cmd;

  always_comb begin
    if (wlen_r == 5'd0) alen = LW'(1);
    else if (32'(wlen_r) > NUM_SLOTS) alen = LW'(NUM_SLOTS);
    else alen = LW'(wlen_r);
  end

  etw_modsub #(.VW(VW), .LW(LW)) u_mod (
    .val_i(acc_r), .len_i(alen), .val_o(sub_val), .done_o(sub_done)
  );

  assign slot     = acc_r[SW-1:0];
  assign alloc_ok = (fcnt_r != '0) || (fresh_r < CW'(CAPACITY));
  assign out_load = (state_r == ST_OUT) && (!ovalid_r || !out_stall);
  assign in_cmd   = cmd_t'(in_command);

  assign in_stall               = (state_r != ST_IDLE);
  assign out_valid              = ovalid_r;
  assign out_expired_descriptor = odesc_r;
  assign out_found              = ofound_r;
  assign out_dropped            = odrop_r;

  // memories: registered reads at node_r and cur_r; writes in the WR and LINK states
  always_ff @(posedge clk) begin
    rval_r  <= mem_val[node_r];
    rlink_r <= mem_link[node_r];
    sh_r    <= shead[cur_r];
    st_r    <= stail[cur_r];
    if (state_r == ST_WR && cmd_r == CMD_INSERT && alloc_ok) begin
      mem_val[node_r]  <= desc_r;
      mem_link[node_r] <= '0;
      if (!sne_r[slot]) shead[slot] <= node_r;
      stail[slot] <= node_r;
    end
    if (state_r == ST_LINK) mem_link[lidx_r] <= ldat_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      wlen_r   <= 5'd16;
      sne_r    <= '0;
      ehead_r  <= '0;
      etail_r  <= '0;
      ene_r    <= 1'b0;
      fhead_r  <= '0;
      fcnt_r   <= '0;
      fresh_r  <= '0;
      cur_r    <= '0;
      ovalid_r <= 1'b0;
    end else begin
      if (cfg_we) wlen_r <= cfg_wheel_length;
      if (out_load) ovalid_r <= 1'b1;
      else if (!out_stall) ovalid_r <= 1'b0;
      unique case (state_r)
        ST_IDLE: begin
          if (in_valid && !in_stall) begin
            cmd_r       <= in_cmd;
            desc_r      <= DESC_WIDTH'(in_descriptor);
            if (in_cmd == CMD_TICK) acc_r <= VW'(cur_r) + VW'(1);
            else acc_r <= VW'(cur_r) + VW'(in_expiration);
            res_desc_r  <= '0;
            res_found_r <= 1'b0;
            res_drop_r  <= 1'b0;
            if (in_cmd == CMD_INSERT)
              node_r <= (fcnt_r != '0) ? fhead_r : fresh_r[AW-1:0];
            else
              node_r <= ehead_r;
            state_r <= (in_cmd == CMD_INSERT || in_cmd == CMD_TICK) ? ST_MOD : ST_RD;
          end
        end
        ST_MOD: begin
          acc_r <= sub_val;
          if (sub_done) state_r <= ST_RD;
        end
        ST_RD: state_r <= ST_WR;
        ST_WR: begin
          unique case (cmd_r)
            CMD_INSERT: begin
              if (fcnt_r != '0) begin
                fhead_r <= rlink_r;
                fcnt_r  <= fcnt_r - CW'(1);
              end else if (alloc_ok) begin
                fresh_r <= fresh_r + CW'(1);
              end else begin
                res_drop_r <= 1'b1;
              end
              if (alloc_ok) begin
                sne_r[slot] <= 1'b1;
                if (sne_r[slot]) begin
                  lidx_r <= stail_q;
                  ldat_r <= node_r;
                end
              end
              state_r <= (alloc_ok && sne_r[slot]) ? ST_LINK : ST_OUT;
            end
            CMD_TICK: begin
              cur_r <= slot;
              if (sne_r[cur_r]) begin
                sne_r[cur_r] <= 1'b0;
                if (ene_r) begin
                  lidx_r <= etail_r;
                  ldat_r <= sh_r;
                end else ehead_r <= sh_r;
                etail_r <= st_r;
                ene_r   <= 1'b1;
              end
              state_r <= (sne_r[cur_r] && ene_r) ? ST_LINK : ST_OUT;
            end
            CMD_COLLECT: begin
              if (ene_r) begin
                res_desc_r  <= 32'(rval_r);
                res_found_r <= 1'b1;
                if (node_r == etail_r) ene_r <= 1'b0;
                else ehead_r <= rlink_r;
                lidx_r  <= node_r;
                ldat_r  <= fhead_r;
                fhead_r <= node_r;
                fcnt_r  <= fcnt_r + CW'(1);
              end
              state_r <= ene_r ? ST_LINK : ST_OUT;
            end
            default: state_r <= ST_OUT;
          endcase
        end
        ST_LINK: state_r <= ST_OUT;
        ST_OUT: begin
          if (out_load) begin
            odesc_r  <= res_desc_r;
            ofound_r <= res_found_r;
            odrop_r  <= res_drop_r;
            state_r  <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_RD) stail_q <= stail[slot];
  end

`ifndef SYNTHESIS
  a_fcnt: assert property (@(posedge clk) disable iff (!rst_n)
    fcnt_r <= fresh_r) else $error("free count exceeds used nodes");
  a_fresh: assert property (@(posedge clk) disable iff (!rst_n)
    32'(fresh_r) <= CAPACITY) else $error("fresh counter overflow");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    ovalid_r && out_stall |=> ovalid_r && $stable(odesc_r))
    else $error("stalled result word changed");
`endif

endmodule
